### design/byte_diff_region_extractor_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the byte difference region extractor
// Same-cycle and next-cycle implication checks, reset-qualified.
// ----------------------------------------------------------------------------
`ifndef BYTE_DIFF_REGION_EXTRACTOR_CORE_ASSERT_SVH
`define BYTE_DIFF_REGION_EXTRACTOR_CORE_ASSERT_SVH

// Check cons in the same cycle as ante
`define BDRE_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("bdre assertion failed");

// Check cons in the cycle after ante
`define BDRE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("bdre assertion failed");

`endif

### design/bdre_pkg.sv
// ----------------------------------------------------------------------------
// bdre_pkg
// Types, constants and helper functions of the byte difference region
// extractor.
// ----------------------------------------------------------------------------
package bdre_pkg;

    localparam int ADDR_W_DEFAULT = 24;
    localparam int ADDR_OUT_W     = 24;
    localparam int LEN_W          = 25;
    localparam int CNT_W          = 24;
    localparam int CAT_W          = 4;
    localparam int CFG_IDX_W      = 2;
    localparam int NUM_SPANS      = 14;
    localparam int NUM_TRACKED    = 10;
    localparam int NUM_CATS       = 11;

    typedef enum logic [1:0] {
        KIND_REGION = 2'd0,
        KIND_COUNT  = 2'd1,
        KIND_TOTALS = 2'd2
    } record_kind_t;

    typedef enum logic [CAT_W-1:0] {
        CAT_GRAPHICS  = 4'd0,
        CAT_OVERWORLD = 4'd1,
        CAT_DUNGEON   = 4'd2,
        CAT_SPRITES   = 4'd3,
        CAT_PALETTES  = 4'd4,
        CAT_MESSAGES  = 4'd5,
        CAT_CODE      = 4'd6,
        CAT_AUDIO     = 4'd7,
        CAT_UNKNOWN   = 4'd8,
        CAT_DATA      = 4'd9,
        CAT_SIZE      = 4'd10
    } category_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEMANTIC_MODE = 2'd0,
        CFG_OLD_SIZE      = 2'd1,
        CFG_NEW_SIZE      = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        SUM_IDLE,
        SUM_COUNTS,
        SUM_TOTALS
    } sum_state_t;

    typedef struct packed {
        logic [7:0] old_byte;
        logic [7:0] new_byte;
        logic       last_pair;
    } in_word_t;

    typedef struct packed {
        record_kind_t          record_kind;
        logic [ADDR_OUT_W-1:0] region_address;
        logic [LEN_W-1:0]      region_length;
        category_t             category;
        logic [LEN_W-1:0]      tally;
        logic [CNT_W-1:0]      region_total;
        logic                  sizes_differ;
        logic                  final_record;
    } out_word_t;

    // Snapshot handed from the scanner to the summary sequencer
    typedef struct packed {
        logic [NUM_TRACKED-1:0][CNT_W-1:0] counts;
        logic [CNT_W-1:0]                  regions;
        logic [LEN_W-1:0]                  changed;
    } summary_load_t;

    // Address ranges, first match wins
    localparam logic [31:0] SPAN_LO [NUM_SPANS] = '{
        32'h000000, 32'h080000, 32'h020000, 32'h0A8000, 32'h028000,
        32'h0B0000, 32'h09C800, 32'h0D8000, 32'h0DD218, 32'h0DE000,
        32'h0E0000, 32'h008000, 32'h018000, 32'h0C0000
    };
    localparam logic [31:0] SPAN_HI [NUM_SPANS] = '{
        32'h00FFFF, 32'h08FFFF, 32'h027FFF, 32'h0AFFFF, 32'h02FFFF,
        32'h0B7FFF, 32'h09DFFF, 32'h0DFFFF, 32'h0DD4FF, 32'h0DEFFF,
        32'h0E7FFF, 32'h00FFFF, 32'h01FFFF, 32'h0CFFFF
    };
    localparam category_t SPAN_CAT [NUM_SPANS] = '{
        CAT_GRAPHICS, CAT_GRAPHICS, CAT_OVERWORLD, CAT_OVERWORLD,
        CAT_DUNGEON, CAT_DUNGEON, CAT_SPRITES, CAT_SPRITES,
        CAT_PALETTES, CAT_PALETTES, CAT_MESSAGES, CAT_CODE, CAT_CODE,
        CAT_AUDIO
    };

    // Pick the category of the first range holding addr
    function automatic category_t classify(input logic [31:0] addr);
        category_t cat;
        cat = CAT_UNKNOWN;
        for (int i = NUM_SPANS - 1; i >= 0; i--) begin
            if (addr >= SPAN_LO[i] && addr <= SPAN_HI[i]) begin
                cat = SPAN_CAT[i];
            end
        end
        return cat;
    endfunction

    function automatic logic [CNT_W-1:0] inc_cnt(input logic [CNT_W-1:0] x);
        return (&x) ? x : x + 1'b1;
    endfunction

    function automatic logic [LEN_W-1:0] inc_len(input logic [LEN_W-1:0] x);
        return (&x) ? x : x + 1'b1;
    endfunction

endpackage

### design/bdre_scan.sv
// ----------------------------------------------------------------------------
// bdre_scan
// Run tracker: compares one byte pair per word, closes runs into region
// words and keeps the running counters.
// ----------------------------------------------------------------------------
module bdre_scan #(
    parameter int ADDRESS_WIDTH = bdre_pkg::ADDR_W_DEFAULT
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    item_go,
    input  bdre_pkg::in_word_t      item,
    input  logic                    semantic_mode,
    output logic                    region_push,
    output bdre_pkg::out_word_t     region_word,
    output logic                    summary_load,
    output bdre_pkg::summary_load_t summary_data
);
    import bdre_pkg::*;

    logic                              in_run_reg;
    logic [ADDRESS_WIDTH-1:0]          run_start_reg;
    logic [LEN_W-1:0]                  run_length_reg;
    logic [ADDRESS_WIDTH-1:0]          position_reg;
    logic [LEN_W-1:0]                  changed_reg;
    logic [CNT_W-1:0]                  regions_reg;
    logic [NUM_TRACKED-1:0][CNT_W-1:0] counts_reg;

    logic                              byte_diff;
    logic [ADDRESS_WIDTH-1:0]          start_cur;
    logic [LEN_W-1:0]                  len_ext;
    logic                              close_hit;
    logic [ADDRESS_WIDTH-1:0]          close_start;
    logic [LEN_W-1:0]                  close_len;
    category_t                         close_cat;
    logic [LEN_W-1:0]                  changed_next;
    logic [CNT_W-1:0]                  regions_next;
    logic [NUM_TRACKED-1:0][CNT_W-1:0] counts_next;

    // Extend or close the current run
    always_comb begin
        byte_diff   = item.old_byte != item.new_byte;
        start_cur   = in_run_reg ? run_start_reg : position_reg;
        len_ext     = in_run_reg ? inc_len(run_length_reg) : LEN_W'(1);
        close_hit   = byte_diff ? item.last_pair : in_run_reg;
        close_start = byte_diff ? start_cur : run_start_reg;
        close_len   = byte_diff ? len_ext : run_length_reg;
        close_cat   = semantic_mode ? classify(32'(close_start)) : CAT_DATA;
    end

    // Counter updates for this word
    always_comb begin
        changed_next = byte_diff ? inc_len(changed_reg) : changed_reg;
        regions_next = close_hit ? inc_cnt(regions_reg) : regions_reg;
        for (int i = 0; i < NUM_TRACKED; i++) begin
            counts_next[i] = (close_hit && close_cat == category_t'(CAT_W'(i))) ?
                             inc_cnt(counts_reg[i]) : counts_reg[i];
        end
    end

    // Region word and summary snapshot
    always_comb begin
        region_word                = '0;
        region_word.record_kind    = KIND_REGION;
        region_word.region_address = ADDR_OUT_W'(close_start);
        region_word.region_length  = close_len;
        region_word.category       = close_cat;
        region_push                = item_go && close_hit;
        summary_load               = item_go && item.last_pair;
        summary_data.counts        = counts_next;
        summary_data.regions       = regions_next;
        summary_data.changed       = changed_next;
    end

    // Advance state, clear after the final pair
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_run_reg     <= 1'b0;
            run_start_reg  <= '0;
            run_length_reg <= '0;
            position_reg   <= '0;
            changed_reg    <= '0;
            regions_reg    <= '0;
            counts_reg     <= '0;
        end else if (item_go) begin
            if (item.last_pair) begin
                in_run_reg     <= 1'b0;
                run_start_reg  <= '0;
                run_length_reg <= '0;
                position_reg   <= '0;
                changed_reg    <= '0;
                regions_reg    <= '0;
                counts_reg     <= '0;
            end else begin
                in_run_reg     <= byte_diff;
                if (byte_diff) begin
                    run_start_reg <= start_cur;
                end
                run_length_reg <= byte_diff ? len_ext : '0;
                position_reg   <= position_reg + 1'b1;
                changed_reg    <= changed_next;
                regions_reg    <= regions_next;
                counts_reg     <= counts_next;
            end
        end
    end

endmodule

### design/bdre_summary.sv
// ----------------------------------------------------------------------------
// bdre_summary
// Summary sequencer: after the final pair, walks the category counts and
// emits one word per nonzero count, then the totals word.
// ----------------------------------------------------------------------------
module bdre_summary (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         load,
    input  bdre_pkg::summary_load_t      load_data,
    input  logic [bdre_pkg::LEN_W-1:0]   old_size,
    input  logic [bdre_pkg::LEN_W-1:0]   new_size,
    input  logic                         can_push,
    output logic                         push,
    output bdre_pkg::out_word_t          push_word,
    output logic                         busy
);
    import bdre_pkg::*;

    sum_state_t                        state_reg;
    sum_state_t                        state_next;
    logic [CAT_W-1:0]                  idx_reg;
    logic [CAT_W-1:0]                  idx_next;
    logic [NUM_TRACKED-1:0][CNT_W-1:0] counts_reg;
    logic [CNT_W-1:0]                  regions_reg;
    logic [LEN_W-1:0]                  changed_reg;
    logic [LEN_W-1:0]                  extra_reg;
    logic                              differ_reg;

    logic [NUM_CATS-1:0][CNT_W-1:0]    all_counts;
    logic [CNT_W-1:0]                  cur_count;
    logic [LEN_W:0]                    total_sum;
    logic [LEN_W-1:0]                  total_tally;
    logic                              last_idx;

    // Size count sits above the tracked categories
    assign all_counts  = {CNT_W'(differ_reg), counts_reg};
    assign cur_count   = all_counts[idx_reg];
    assign last_idx    = idx_reg == CAT_W'(NUM_CATS - 1);
    assign total_sum   = {1'b0, changed_reg} + {1'b0, extra_reg};
    assign total_tally = total_sum[LEN_W] ? {LEN_W{1'b1}} : total_sum[LEN_W-1:0];
    assign busy        = state_reg != SUM_IDLE;

    // Capture the snapshot and the size mismatch
    always_ff @(posedge aclk) begin
        if (load) begin
            counts_reg  <= load_data.counts;
            regions_reg <= load_data.regions;
            changed_reg <= load_data.changed;
            differ_reg  <= old_size != new_size;
            extra_reg   <= (new_size > old_size) ? new_size - old_size : '0;
        end
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SUM_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // Next state and words
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        push       = 1'b0;
        push_word  = '0;
        unique case (state_reg)
            SUM_IDLE: begin
                if (load) begin
                    state_next = SUM_COUNTS;
                    idx_next   = '0;
                end
            end
            SUM_COUNTS: begin
                push_word.record_kind = KIND_COUNT;
                push_word.category    = category_t'(idx_reg);
                push_word.tally       = LEN_W'(cur_count);
                // skip empty categories, hold while the output is full
                if (cur_count == '0 || can_push) begin
                    push = cur_count != '0;
                    if (last_idx) begin
                        state_next = SUM_TOTALS;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            SUM_TOTALS: begin
                push_word.record_kind  = KIND_TOTALS;
                push_word.category     = CAT_GRAPHICS;
                push_word.tally        = total_tally;
                push_word.region_total = regions_reg;
                push_word.sizes_differ = differ_reg;
                push_word.final_record = 1'b1;
                if (can_push) begin
                    push       = 1'b1;
                    state_next = SUM_IDLE;
                end
            end
            default: begin
                state_next = SUM_IDLE;
            end
        endcase
    end

endmodule

### design/bdre_out_fifo.sv
// ----------------------------------------------------------------------------
// bdre_out_fifo
// Two-entry output buffer that decouples result backpressure from the
// scanner.
// ----------------------------------------------------------------------------
module bdre_out_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  bdre_pkg::out_word_t push_word,
    output logic                full,
    output logic                m_valid,
    input  logic                m_ready,
    output bdre_pkg::out_word_t m_data
);
    import bdre_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int OCC_W = $clog2(DEPTH + 1);

    out_word_t        entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [OCC_W-1:0] occ_reg;
    logic             pop;

    assign full    = occ_reg == OCC_W'(DEPTH);
    assign m_valid = occ_reg != '0;
    assign m_data  = entry_reg[rd_ptr_reg];
    assign pop     = m_valid && m_ready;

    // Store pushed words
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_word;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            occ_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                occ_reg <= occ_reg + 1'b1;
            end else if (pop && !push) begin
                occ_reg <= occ_reg - 1'b1;
            end
        end
    end

endmodule

### design/byte_diff_region_extractor_core.sv
// ----------------------------------------------------------------------------
// byte_diff_region_extractor_core
// A region word shows on m_valid in the cycle after the pair that ends its
// run is taken. Throughput: one pair per cycle, set by the input register
// feeding the run tracker, unless a full output or a summary stalls it.
// After the final pair the sequencer walks each category slot, then
// the totals word, holding while the output is full; the tracker takes no
// pair then, the input register holds one. Reset (aresetn low, synchronous)
// clears all counters, the configuration registers and both buffers.
// ----------------------------------------------------------------------------
`include "byte_diff_region_extractor_core_assert.svh"

module byte_diff_region_extractor_core #(
    parameter int ADDRESS_WIDTH = bdre_pkg::ADDR_W_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  bdre_pkg::in_word_t             s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output bdre_pkg::out_word_t            m_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bdre_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bdre_pkg::LEN_W-1:0]     cfg_data
);
    import bdre_pkg::*;

    logic             semantic_mode_reg;
    logic [LEN_W-1:0] old_size_reg;
    logic [LEN_W-1:0] new_size_reg;

    logic             in_vld_reg;
    in_word_t         in_word_reg;
    logic             consume;

    logic             region_push;
    out_word_t        region_word;
    logic             summary_load;
    summary_load_t    summary_data;
    logic             sum_push;
    out_word_t        sum_word;
    logic             sum_busy;
    logic             fifo_push;
    out_word_t        fifo_word;
    logic             out_full;

    // Configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            semantic_mode_reg <= 1'b0;
            old_size_reg      <= '0;
            new_size_reg      <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SEMANTIC_MODE: semantic_mode_reg <= cfg_data[0];
                CFG_OLD_SIZE:      old_size_reg      <= cfg_data;
                CFG_NEW_SIZE:      new_size_reg      <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Input register: hold a word until the tracker takes it
    assign consume = in_vld_reg && !out_full && !sum_busy;
    assign s_ready = !in_vld_reg || consume;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_word_reg <= s_data;
        end
    end

    bdre_scan #(
        .ADDRESS_WIDTH (ADDRESS_WIDTH)
    ) u_scan (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .item_go       (consume),
        .item          (in_word_reg),
        .semantic_mode (semantic_mode_reg),
        .region_push   (region_push),
        .region_word   (region_word),
        .summary_load  (summary_load),
        .summary_data  (summary_data)
    );

    bdre_summary u_summary (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (summary_load),
        .load_data (summary_data),
        .old_size  (old_size_reg),
        .new_size  (new_size_reg),
        .can_push  (!out_full),
        .push      (sum_push),
        .push_word (sum_word),
        .busy      (sum_busy)
    );

    // Merge the two word sources, at most one pushes per cycle
    assign fifo_push = region_push || sum_push;
    assign fifo_word = region_push ? region_word : sum_word;

    bdre_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (fifo_push),
        .push_word (fifo_word),
        .full      (out_full),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    `BDRE_ASSERT_NOW(a_single_push, aclk, aresetn, region_push, !sum_push)
    `BDRE_ASSERT_NEXT(a_summary_follows, aclk, aresetn, consume && in_word_reg.last_pair, sum_busy)
    `BDRE_ASSERT_NOW(a_final_totals, aclk, aresetn, m_valid && m_data.final_record, m_data.record_kind == KIND_TOTALS)
    `BDRE_ASSERT_NOW(a_no_push_full, aclk, aresetn, out_full, !fifo_push)

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: byte difference region extractor bench
// Streams byte pairs into the core and checks every region, category count
// and totals word against a cycle-free tracker kept here. Covers single-pair
// comparisons, runs at the edges of a comparison, size mismatches both ways,
// semantic labeling of runs near the start of the image, output back-pressure
// and random comparisons under several register settings and idle patterns.
// ----------------------------------------------------------------------------
module tb_top;
    import bdre_pkg::*;

    localparam int ADDR_W       = 24;
    localparam int IDLE_GAP     = 20;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_PAIRS = 260;
    localparam int FAR_LAST     = 24;
    localparam logic [24:0] SIZE_MAX = 25'h1000000;

    typedef enum int {
        RX_STEADY,
        RX_RANDOM,
        RX_PATTERN
    } rx_mode_t;

    // Address ranges, first match wins
    localparam logic [23:0] AREA_LO [14] = '{
        24'h000000, 24'h080000, 24'h020000, 24'h0A8000, 24'h028000,
        24'h0B0000, 24'h09C800, 24'h0D8000, 24'h0DD218, 24'h0DE000,
        24'h0E0000, 24'h008000, 24'h018000, 24'h0C0000
    };
    localparam logic [23:0] AREA_HI [14] = '{
        24'h00FFFF, 24'h08FFFF, 24'h027FFF, 24'h0AFFFF, 24'h02FFFF,
        24'h0B7FFF, 24'h09DFFF, 24'h0DFFFF, 24'h0DD4FF, 24'h0DEFFF,
        24'h0E7FFF, 24'h00FFFF, 24'h01FFFF, 24'h0CFFFF
    };
    localparam category_t AREA_CAT [14] = '{
        CAT_GRAPHICS, CAT_GRAPHICS, CAT_OVERWORLD, CAT_OVERWORLD,
        CAT_DUNGEON, CAT_DUNGEON, CAT_SPRITES, CAT_SPRITES,
        CAT_PALETTES, CAT_PALETTES, CAT_MESSAGES, CAT_CODE, CAT_CODE,
        CAT_AUDIO
    };

    // Differing runs for the semantic labeling test, the last one ends the
    // comparison
    localparam int MARK_AT [8] = '{
        'h00, 'h03, 'h06, 'h09, 'h0C, 'h10, 'h14, 'h17
    };
    localparam int MARK_LEN [8] = '{2, 1, 1, 2, 1, 1, 1, 2};

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    in_word_t    s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    out_word_t   m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    cfg_index_t  cfg_index = CFG_SEMANTIC_MODE;
    logic [24:0] cfg_data  = '0;

    // Tracker state and register copies
    logic        trk_in_run;
    logic [23:0] trk_start;
    logic [24:0] trk_len;
    logic [ADDR_W-1:0] trk_pos;
    logic [24:0] trk_changed;
    logic [23:0] trk_regions;
    logic [23:0] trk_cat_cnt [NUM_CATS];
    logic        mode_semantic = 1'b0;
    logic [24:0] size_old      = '0;
    logic [24:0] size_new      = '0;

    out_word_t   pending_records [$];
    out_word_t   chk_want;

    // Idle control
    rx_mode_t    rx_mode   = RX_STEADY;
    bit          tx_gappy  = 1'b0;
    bit          hold_req  = 1'b0;
    int          burst_left = 0;

    int pairs_sent    = 0;
    int compares_done = 0;
    int words_checked = 0;
    int region_words  = 0;
    int cfg_writes    = 0;
    int mismatches    = 0;

    byte_diff_region_extractor_core #(
        .ADDRESS_WIDTH(ADDR_W)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Tracker
    // ------------------------------------------------------------------
    function automatic category_t region_class(input logic [23:0] addr);
        for (int i = 0; i < 14; i++) begin
            if (addr >= AREA_LO[i] && addr <= AREA_HI[i]) begin
                return AREA_CAT[i];
            end
        end
        return CAT_UNKNOWN;
    endfunction

    task automatic clear_tracker();
        trk_in_run  = 1'b0;
        trk_start   = '0;
        trk_len     = '0;
        trk_pos     = '0;
        trk_changed = '0;
        trk_regions = '0;
        for (int c = 0; c < NUM_CATS; c++) begin
            trk_cat_cnt[c] = '0;
        end
    endtask

    // Emit the region word of the open run and count it
    task automatic close_region();
        out_word_t w;
        category_t cat;
        cat = mode_semantic ? region_class(trk_start) : CAT_DATA;
        w = '0;
        w.record_kind    = KIND_REGION;
        w.region_address = trk_start;
        w.region_length  = trk_len;
        w.category       = cat;
        pending_records = {pending_records, w};
        if (trk_regions != '1) trk_regions++;
        if (trk_cat_cnt[cat] != '1) trk_cat_cnt[cat]++;
        trk_in_run = 1'b0;
        trk_len    = '0;
    endtask

    task automatic track_pair(input in_word_t p);
        out_word_t   w;
        logic [25:0] sum;
        bit          differ;
        if (p.old_byte != p.new_byte) begin
            if (!trk_in_run) begin
                trk_in_run = 1'b1;
                trk_start  = trk_pos;
                trk_len    = '0;
            end
            if (trk_len != '1) trk_len++;
            if (trk_changed != '1) trk_changed++;
        end else if (trk_in_run) begin
            close_region();
        end
        trk_pos = trk_pos + 1'b1;
        if (!p.last_pair) return;

        // Close out the comparison
        if (trk_in_run) close_region();
        differ = (size_old != size_new);
        if (differ) begin
            trk_cat_cnt[CAT_SIZE] = 24'd1;
            if (size_new > size_old) begin
                sum = {1'b0, trk_changed} + {1'b0, size_new - size_old};
                trk_changed = sum[25] ? '1 : sum[24:0];
            end
        end
        for (int c = 0; c < NUM_CATS; c++) begin
            if (trk_cat_cnt[c] != '0) begin
                w = '0;
                w.record_kind = KIND_COUNT;
                w.category    = category_t'(c);
                w.tally       = {1'b0, trk_cat_cnt[c]};
                pending_records = {pending_records, w};
            end
        end
        w = '0;
        w.record_kind  = KIND_TOTALS;
        w.category     = CAT_GRAPHICS;
        w.tally        = trk_changed;
        w.region_total = trk_regions;
        w.sizes_differ = differ;
        w.final_record = 1'b1;
        pending_records = {pending_records, w};
        compares_done++;
        clear_tracker();
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_records.size() == 0) begin
                $error("unexpected result word %p", m_data);
                mismatches++;
            end else begin
                chk_want = pending_records.pop_front();
                check_field("record_kind", chk_want.record_kind, m_data.record_kind);
                check_field("region_address", chk_want.region_address,
                            m_data.region_address);
                check_field("region_length", chk_want.region_length,
                            m_data.region_length);
                check_field("category", chk_want.category, m_data.category);
                check_field("tally", chk_want.tally, m_data.tally);
                check_field("region_total", chk_want.region_total, m_data.region_total);
                check_field("sizes_differ", chk_want.sizes_differ, m_data.sizes_differ);
                check_field("final_record", chk_want.final_record, m_data.final_record);
                words_checked++;
                if (chk_want.record_kind == KIND_REGION) region_words++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver stalls: steady, random or a fixed repeating 16-bit pattern,
    // overridden by a long hold-off on request
    // ------------------------------------------------------------------
    int rx_hold = 0;
    int rx_tick = 0;
    localparam logic [15:0] RX_SHAPE = 16'b1101_0011_1011_0001;

    always @(posedge aclk) begin
        if (hold_req) begin
            rx_hold  = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        rx_tick++;
        if (rx_hold > 0) begin
            rx_hold--;
            m_ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_STEADY:  m_ready <= 1'b1;
                RX_RANDOM:  m_ready <= ($urandom_range(0, 99) < 60);
                default:    m_ready <= RX_SHAPE[rx_tick % 16];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Offer one pair, hold it until taken, then maybe drop valid for a gap
    task automatic send_pair(input in_word_t p);
        s_data  <= p;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        track_pair(p);
        pairs_sent++;
        if (tx_gappy) begin
            if (burst_left == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge aclk);
                burst_left = $urandom_range(0, 12);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic end_stream();
        if (s_valid) s_valid <= 1'b0;
    endtask

    // Let every expected word drain and the summary sequencer settle
    task automatic wait_idle();
        end_stream();
        while (pending_records.size() != 0) @(posedge aclk);
        repeat (IDLE_GAP) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [24:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_SEMANTIC_MODE: mode_semantic = val[0];
            CFG_OLD_SIZE:      size_old      = val;
            CFG_NEW_SIZE:      size_new      = val;
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic set_config(input bit sem, input logic [24:0] old_sz,
                              input logic [24:0] new_sz);
        wait_idle();
        write_reg(CFG_SEMANTIC_MODE, {24'd0, sem});
        write_reg(CFG_OLD_SIZE, old_sz);
        write_reg(CFG_NEW_SIZE, new_sz);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [24:0] pick_size();
        case ($urandom_range(0, 4))
            0:       return 25'd0;
            1:       return SIZE_MAX;
            2:       return 25'd1;
            default: return 25'($urandom_range(0, SIZE_MAX));
        endcase
    endfunction

    task automatic send_fixed(input logic [7:0] ob, input logic [7:0] nb,
                              input bit last);
        in_word_t p;
        p.old_byte  = ob;
        p.new_byte  = nb;
        p.last_pair = last;
        send_pair(p);
    endtask

    // One comparison of n pairs; differing stretches come in runs
    task automatic run_comparison(input int n);
        in_word_t p;
        int       flip_pct;
        bit       hot;
        flip_pct = $urandom_range(5, 70);
        hot      = 1'($urandom_range(0, 1));
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < flip_pct) hot = !hot;
            p.old_byte  = 8'($urandom);
            p.new_byte  = hot ? p.old_byte ^ 8'($urandom_range(1, 255)) : p.old_byte;
            p.last_pair = (i == n - 1);
            send_pair(p);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset registers: one equal pair, then one differing pair
    task automatic test_single_pair();
        send_fixed(8'h00, 8'h00, 1'b1);
        send_fixed(8'h00, 8'hFF, 1'b1);
    endtask

    // Runs at the start, in the middle and through the final pair
    task automatic test_run_edges();
        set_config(1'b0, SIZE_MAX, SIZE_MAX);
        send_fixed(8'h00, 8'hFF, 1'b0);
        send_fixed(8'hFF, 8'h00, 1'b0);
        send_fixed(8'hFF, 8'hFF, 1'b0);
        send_fixed(8'h12, 8'h13, 1'b0);
        send_fixed(8'h00, 8'h00, 1'b0);
        send_fixed(8'hAA, 8'h55, 1'b0);
        send_fixed(8'h55, 8'hAA, 1'b1);
    endtask

    // Size mismatch with each image longer, in both labeling modes
    task automatic test_size_mismatch();
        set_config(1'b1, SIZE_MAX, 25'd0);
        send_fixed(8'h01, 8'h01, 1'b0);
        send_fixed(8'h02, 8'h03, 1'b1);
        set_config(1'b0, 25'd0, SIZE_MAX);
        send_fixed(8'h7F, 8'h80, 1'b0);
        send_fixed(8'h80, 8'h7F, 1'b1);
        set_config(1'b1, 25'd5, 25'd6);
        send_fixed(8'hC3, 8'h3C, 1'b0);
        send_fixed(8'h3C, 8'h3C, 1'b1);
    endtask

    // Label several short runs by the address table, streaming back to back,
    // with the last run open through the final pair
    task automatic test_address_table();
        in_word_t p;
        bit       hit;
        set_config(1'b1, 25'h30000, 25'h30000);
        tx_gappy = 1'b0;
        rx_mode  = RX_STEADY;
        for (int a = 0; a <= FAR_LAST; a++) begin
            hit = 1'b0;
            for (int m = 0; m < 8; m++) begin
                if (a >= MARK_AT[m] && a < MARK_AT[m] + MARK_LEN[m]) hit = 1'b1;
            end
            p.old_byte  = a[7:0];
            p.new_byte  = hit ? ~a[7:0] : a[7:0];
            p.last_pair = (a == FAR_LAST);
            send_pair(p);
        end
    endtask

    // Hold off the receiver while the sender keeps going, so the core backs up
    task automatic test_output_backpressure();
        set_config(1'b0, 25'd100, 25'd90);
        tx_gappy = 1'b0;
        rx_mode  = RX_STEADY;
        hold_req = 1'b1;
        for (int k = 0; k < 4; k++) begin
            run_comparison(15);
        end
        wait_idle();
    endtask

    task automatic test_random_comparisons();
        int start_pairs;
        int n;
        start_pairs = pairs_sent;
        while (pairs_sent - start_pairs < RANDOM_PAIRS) begin
            if ($urandom_range(0, 99) < 35) begin
                set_config(1'($urandom_range(0, 1)), pick_size(), pick_size());
            end
            rx_mode  = rx_mode_t'($urandom_range(0, 2));
            tx_gappy = 1'($urandom_range(0, 1));
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 64)
                                            : $urandom_range(1, 20);
            run_comparison(n);
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        clear_tracker();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_gappy = 1'b1;
        rx_mode  = RX_RANDOM;
        test_single_pair();
        test_run_edges();
        test_size_mismatch();
        test_address_table();
        test_output_backpressure();
        test_random_comparisons();

        wait_idle();
        $display("Ran %0d comparisons over %0d byte pairs, %0d register writes",
                 compares_done, pairs_sent, cfg_writes);
        $display("Checked %0d result words (%0d regions), %0d mismatches",
                 words_checked, region_words, mismatches);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Run limit
    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
